>>> hw/rtl/dea_pkg.sv
`default_nettype none
package dea_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int COMPONENT_WIDTH_DEF = 16;

    // angle inside the CORDIC: degrees, 16 fraction bits
    localparam int ANG_W = 26;
    // angle after rounding: degrees, 8 fraction bits
    localparam int Q_W   = ANG_W - 8;

    localparam int PITCH_W     = 16;
    localparam int YAW_W       = 17;
    localparam int OUT_TDATA_W = 40;
    localparam int ATAN_LEN    = 24;

    localparam logic signed [ANG_W-1:0] ANG_90     = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_180    = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 26'sd128;

    localparam logic signed [Q_W-1:0] PITCH_LIMIT = 18'sd23040;
    localparam logic signed [Q_W-1:0] PITCH_CLAMP = 18'sd22784;
    localparam logic signed [Q_W-1:0] YAW_LIMIT   = 18'sd46080;
    localparam logic signed [Q_W-1:0] YAW_TURN    = 18'sd92160;

    // register index as seen in paddr[2]
    localparam logic REG_IDX_PITCH_CLAMP = 1'b0;

    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_POS90,
        SPEC_NEG90,
        SPEC_POS180
    } spec_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 26'sd2949120;
            5'd1:    val = 26'sd1740967;
            5'd2:    val = 26'sd919879;
            5'd3:    val = 26'sd466945;
            5'd4:    val = 26'sd234379;
            5'd5:    val = 26'sd117304;
            5'd6:    val = 26'sd58666;
            5'd7:    val = 26'sd29335;
            5'd8:    val = 26'sd14668;
            5'd9:    val = 26'sd7334;
            5'd10:   val = 26'sd3667;
            5'd11:   val = 26'sd1833;
            5'd12:   val = 26'sd917;
            5'd13:   val = 26'sd458;
            5'd14:   val = 26'sd229;
            5'd15:   val = 26'sd115;
            5'd16:   val = 26'sd57;
            5'd17:   val = 26'sd29;
            5'd18:   val = 26'sd14;
            5'd19:   val = 26'sd7;
            5'd20:   val = 26'sd4;
            5'd21:   val = 26'sd2;
            5'd22:   val = 26'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dea_isqrt.sv
`default_nettype none
module dea_isqrt import dea_pkg::*; #(
    parameter int CW     = COMPONENT_WIDTH_DEF,
    parameter int SIDE_W = 3 * COMPONENT_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [2*CW-1:0]     radicand,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     out_valid,
    output logic [CW-1:0]            root,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int TW = 2 * CW + 1;

    logic [TW-1:0]     rem_reg   [CW];
    logic [CW-1:0]     root_reg  [CW];
    logic [SIDE_W-1:0] side_reg  [CW];
    logic              valid_reg [CW];

    // one result bit per stage, most significant first
    for (genvar k = 0; k < CW; k++) begin : g_stage
        localparam int BIT = CW - 1 - k;

        logic [TW-1:0]     rem_prev;
        logic [CW-1:0]     root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [TW-1:0]     trial;

        if (k == 0) begin : g_first
            assign rem_prev   = TW'(radicand);
            assign root_prev  = '0;
            assign side_prev  = side_in;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        assign trial = (TW'(root_prev) << (BIT + 1)) | (TW'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_prev;
                if (rem_prev >= trial) begin
                    rem_reg[k]  <= rem_prev - trial;
                    root_reg[k] <= root_prev | (CW'(1) << BIT);
                end else begin
                    rem_reg[k]  <= rem_prev;
                    root_reg[k] <= root_prev;
                end
            end
        end
    end

    assign out_valid = valid_reg[CW-1];
    assign root      = root_reg[CW-1];
    assign side_out  = side_reg[CW-1];

endmodule
`default_nettype wire

>>> hw/rtl/dea_cordic.sv
`default_nettype none
module dea_cordic import dea_pkg::*; #(
    parameter int IN_W  = COMPONENT_WIDTH_DEF + 1,
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [IN_W-1:0]  a_in,
    input  wire logic signed [IN_W-1:0]  b_in,
    output logic                         out_valid,
    output logic signed [ANG_W-1:0]      angle
);

    localparam int W = IN_W + STEPS + 2;

    logic signed [W-1:0]     a0_reg;
    logic signed [W-1:0]     b0_reg;
    logic signed [ANG_W-1:0] z0_reg;
    spec_t                   spec0_reg;
    logic                    valid0_reg;

    logic signed [W-1:0]     a_reg     [STEPS];
    logic signed [W-1:0]     b_reg     [STEPS];
    logic signed [ANG_W-1:0] z_reg     [STEPS];
    spec_t                   spec_reg  [STEPS];
    logic                    valid_reg [STEPS];

    logic                    neg;
    logic signed [W-1:0]     a_ext;
    logic signed [W-1:0]     b_ext;
    logic signed [W-1:0]     a0_next;
    logic signed [W-1:0]     b0_next;
    logic signed [ANG_W-1:0] z0_next;
    spec_t                   spec0_next;

    // fold the left half plane onto the right and flag the exact cases
    always_comb begin
        neg   = a_in[IN_W-1];
        a_ext = W'(a_in);
        b_ext = W'(b_in);
        if (neg) begin
            a0_next = (-a_ext) <<< STEPS;
            b0_next = (-b_ext) <<< STEPS;
            z0_next = b_in[IN_W-1] ? -ANG_180 : ANG_180;
        end else begin
            a0_next = a_ext <<< STEPS;
            b0_next = b_ext <<< STEPS;
            z0_next = '0;
        end
        if (b_in == '0) begin
            spec0_next = neg ? SPEC_POS180 : SPEC_ZERO;
        end else if (a_in == '0) begin
            spec0_next = b_in[IN_W-1] ? SPEC_NEG90 : SPEC_POS90;
        end else begin
            spec0_next = SPEC_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg    <= a0_next;
            b0_reg    <= b0_next;
            z0_reg    <= z0_next;
            spec0_reg <= spec0_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [W-1:0]     a_prev;
        logic signed [W-1:0]     b_prev;
        logic signed [ANG_W-1:0] z_prev;
        spec_t                   spec_prev;
        logic                    valid_prev;
        logic signed [W-1:0]     da;
        logic signed [W-1:0]     db;
        logic signed [ANG_W-1:0] step_ang;

        if (i == 0) begin : g_first
            assign a_prev     = a0_reg;
            assign b_prev     = b0_reg;
            assign z_prev     = z0_reg;
            assign spec_prev  = spec0_reg;
            assign valid_prev = valid0_reg;
        end else begin : g_rest
            assign a_prev     = a_reg[i-1];
            assign b_prev     = b_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign spec_prev  = spec_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        assign da       = b_prev >>> i;
        assign db       = a_prev >>> i;
        assign step_ang = atan_q16(5'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        // rotate toward the positive a axis
        always_ff @(posedge aclk) begin
            if (en) begin
                spec_reg[i] <= spec_prev;
                if (!b_prev[W-1]) begin
                    a_reg[i] <= a_prev + da;
                    b_reg[i] <= b_prev - db;
                    z_reg[i] <= z_prev + step_ang;
                end else begin
                    a_reg[i] <= a_prev - da;
                    b_reg[i] <= b_prev + db;
                    z_reg[i] <= z_prev - step_ang;
                end
            end
        end
    end

    always_comb begin
        case (spec_reg[STEPS-1])
            SPEC_NONE:   angle = z_reg[STEPS-1];
            SPEC_ZERO:   angle = '0;
            SPEC_POS90:  angle = ANG_90;
            SPEC_NEG90:  angle = -ANG_90;
            SPEC_POS180: angle = ANG_180;
            default:     angle = z_reg[STEPS-1];
        endcase
    end

    assign out_valid = valid_reg[STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/direction_to_euler_angles.sv
// Direction vector to pitch/yaw converter (y axis up).
// Input stream: s_tvalid/s_tready/s_tdata carries one vector dir_x, dir_y, dir_z
// per request. Result stream: m_tvalid/m_tready/m_tdata carries pitch_deg,
// yaw_deg (degrees, 8 fraction bits) and roll_deg, which is always zero.
// A request enters every cycle while s_tready is high. The pipeline runs input
// capture, squares, sum of squares and the square root, one result bit per
// stage, followed by two vectoring CORDICs with a fold of the input and one
// rotation per stage, run side by side for pitch and yaw, then the register
// for the rounded angles and the output register.
// APB register 0 (byte address 0), bit 0: pitch clamp to +-89 degrees.
// Reset empties the pipeline and clears the clamp enable; s_tready rises in the
// first cycle after reset. When the receiver stalls, one result is held in the
// output register and one more in a skid register, after which the whole
// pipeline holds and s_tready drops until the skid register drains.
`default_nettype none
module direction_to_euler_angles import dea_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int IN_TDATA_W      = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // dir_x, dir_y, dir_z
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // pitch_deg, yaw_deg, roll_deg

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int SIDE_W = 3 * CW;
    localparam int C_W    = CW + 1;

    // configuration
    logic clamp_en_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_en_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_IDX_PITCH_CLAMP) begin
            clamp_en_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_PITCH_CLAMP) begin
            prdata[0] = clamp_en_reg;
        end
    end

    // pipeline enable: the whole pipe holds while the skid register is full
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en && aresetn;

    // input capture
    logic                 v0_reg;
    logic signed [CW-1:0] x0_reg, y0_reg, z0_reg;

    // squares
    logic                 v1_reg;
    logic [2*CW-1:0]      xx1_reg, zz1_reg;
    logic [SIDE_W-1:0]    side1_reg;
    logic signed [2*CW-1:0] xx_prod, zz_prod;

    // sum of squares
    logic                 v2_reg;
    logic [2*CW-1:0]      hsq2_reg;
    logic [SIDE_W-1:0]    side2_reg;

    assign xx_prod = x0_reg * x0_reg;
    assign zz_prod = z0_reg * z0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= s_tdata[CW-1:0];
            y0_reg    <= s_tdata[2*CW-1:CW];
            z0_reg    <= s_tdata[3*CW-1:2*CW];
            xx1_reg   <= xx_prod;
            zz1_reg   <= zz_prod;
            side1_reg <= {z0_reg, y0_reg, x0_reg};
            hsq2_reg  <= xx1_reg + zz1_reg;
            side2_reg <= side1_reg;
        end
    end

    // horizontal length
    logic              sq_valid;
    logic [CW-1:0]     h_len;
    logic [SIDE_W-1:0] sq_side;

    dea_isqrt #(
        .CW     (CW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .radicand  (hsq2_reg),
        .side_in   (side2_reg),
        .out_valid (sq_valid),
        .root      (h_len),
        .side_out  (sq_side)
    );

    logic [CW-1:0] sq_x, sq_y, sq_z;

    assign sq_x = sq_side[CW-1:0];
    assign sq_y = sq_side[2*CW-1:CW];
    assign sq_z = sq_side[3*CW-1:2*CW];

    // angles
    logic                    pitch_valid, yaw_valid;
    logic signed [ANG_W-1:0] pitch_ang, yaw_ang;

    dea_cordic #(
        .IN_W  (C_W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .a_in      ({1'b0, h_len}),
        .b_in      ({sq_y[CW-1], sq_y}),
        .out_valid (pitch_valid),
        .angle     (pitch_ang)
    );

    dea_cordic #(
        .IN_W  (C_W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .a_in      ({sq_x[CW-1], sq_x}),
        .b_in      ({sq_z[CW-1], sq_z}),
        .out_valid (yaw_valid),
        .angle     (yaw_ang)
    );

    // round to 8 fraction bits, limit pitch, wrap yaw
    logic signed [ANG_W-1:0] pitch_sum, yaw_sum;
    logic signed [Q_W-1:0]   pitch_q, yaw_q;
    logic signed [Q_W-1:0]   pitch_next, yaw_next;

    always_comb begin
        pitch_sum = pitch_ang + ROUND_HALF;
        yaw_sum   = yaw_ang + ROUND_HALF;
        pitch_q   = $signed(pitch_sum[ANG_W-1:8]);
        yaw_q     = $signed(yaw_sum[ANG_W-1:8]);

        pitch_next = pitch_q;
        if (pitch_q > PITCH_LIMIT) begin
            pitch_next = PITCH_LIMIT;
        end else if (pitch_q < -PITCH_LIMIT) begin
            pitch_next = -PITCH_LIMIT;
        end
        if (clamp_en_reg) begin
            if (pitch_q > PITCH_CLAMP) begin
                pitch_next = PITCH_CLAMP;
            end else if (pitch_q < -PITCH_CLAMP) begin
                pitch_next = -PITCH_CLAMP;
            end
        end

        yaw_next = yaw_q;
        if (yaw_q < -YAW_LIMIT) begin
            yaw_next = yaw_q + YAW_TURN;
        end else if (yaw_q > YAW_LIMIT) begin
            yaw_next = yaw_q - YAW_TURN;
        end
    end

    logic               tail_valid_reg;
    logic [PITCH_W-1:0] tail_pitch_reg;
    logic [YAW_W-1:0]   tail_yaw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_valid_reg <= 1'b0;
        end else if (en) begin
            tail_valid_reg <= pitch_valid && yaw_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_pitch_reg <= pitch_next[PITCH_W-1:0];
            tail_yaw_reg   <= yaw_next[YAW_W-1:0];
        end
    end

    // output register with skid stage
    logic               out_valid_reg;
    logic [PITCH_W-1:0] out_pitch_reg, skid_pitch_reg;
    logic [YAW_W-1:0]   out_yaw_reg, skid_yaw_reg;
    logic               take;

    assign take = en && tail_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_pitch_reg <= skid_pitch_reg;
                out_yaw_reg   <= skid_yaw_reg;
            end else begin
                out_pitch_reg <= tail_pitch_reg;
                out_yaw_reg   <= tail_yaw_reg;
            end
        end else if (take) begin
            skid_pitch_reg <= tail_pitch_reg;
            skid_yaw_reg   <= tail_yaw_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - PITCH_W - YAW_W - 1){1'b0}}, 1'b0,
                       out_yaw_reg, out_pitch_reg};

endmodule
`default_nettype wire
